// File: rtl/u8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg - shared types and constants of the UTF-8 code point decoder
// Command word passed from the byte classifier to the sequence engine, queue
// sizing and the status bundle seen by the top level.
// ----------------------------------------------------------------------------
package u8d_pkg;

    // Widths fixed by the stream format
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Command queue between classifier and engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Class of one input byte
    typedef enum logic [1:0] {
        CMD_NUL,    // string terminator
        CMD_IMM,    // ASCII, invalid lead: stands for itself
        CMD_CONT,   // continuation byte 10xxxxxx
        CMD_LEAD    // multi-byte lead, payload pre-shifted
    } cmd_kind_t;

    // One classified byte
    typedef struct packed {
        cmd_kind_t         kind;
        logic [1:0]        len;     // continuation bytes a lead announces
        logic [CP_W-1:0]   value;   // raw byte, or lead payload in place
    } cmd_t;

    // Engine status for the top-level checks
    typedef struct packed {
        logic [1:0]        bytes_remaining;
        logic [CP_W-1:0]   accumulator;
        logic              pend_valid;
        logic              pop;
    } back_status_t;

endpackage
`default_nettype wire

// File: rtl/u8d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_front - byte classifier
// Sorts each incoming byte into terminator, stand-alone, continuation or
// lead, and pre-shifts a lead's payload bits to their final place.
// ----------------------------------------------------------------------------
module u8d_front (
    input  wire logic [u8d_pkg::BYTE_W-1:0] byte_in,
    output u8d_pkg::cmd_t                   cmd
);

    // Classify on the leading one bits
    always_comb
    begin
        cmd.kind  = u8d_pkg::CMD_IMM;
        cmd.len   = 2'd0;
        cmd.value = {{(u8d_pkg::CP_W - u8d_pkg::BYTE_W){1'b0}}, byte_in};
        if (byte_in == '0)
        begin
            cmd.kind = u8d_pkg::CMD_NUL;
        end
        else if (byte_in[7] == 1'b0)
        begin
            cmd.kind = u8d_pkg::CMD_IMM;
        end
        else if (byte_in[7:6] == 2'b10)
        begin
            cmd.kind = u8d_pkg::CMD_CONT;
        end
        else if (byte_in[7:5] == 3'b110)
        begin
            cmd.kind  = u8d_pkg::CMD_LEAD;
            cmd.len   = 2'd1;
            cmd.value = {10'd0, byte_in[4:0], 6'd0};
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            cmd.kind  = u8d_pkg::CMD_LEAD;
            cmd.len   = 2'd2;
            cmd.value = {5'd0, byte_in[3:0], 12'd0};
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            cmd.kind  = u8d_pkg::CMD_LEAD;
            cmd.len   = 2'd3;
            cmd.value = {byte_in[2:0], 18'd0};
        end
        // 0xF8 and above stay as stand-alone raw bytes
    end

endmodule
`default_nettype wire

// File: rtl/u8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_queue - command queue
// Small first-in first-out store of classified bytes; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module u8d_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire u8d_pkg::cmd_t push_cmd,
    output logic               full,
    output logic               pop_valid,
    output u8d_pkg::cmd_t      pop_cmd,
    input  wire logic          pop
);

    u8d_pkg::cmd_t                     slot_reg [u8d_pkg::QUEUE_DEPTH];
    logic [u8d_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [u8d_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [u8d_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                              do_push, do_pop;

    assign full      = (count_reg == u8d_pkg::QUEUE_CNT_W'(u8d_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/u8d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_back - sequence engine
// Holds the decode state, folds each command into the accumulator and
// delivers up to two code points per command through an output register
// and a one-word pending slot.
// ----------------------------------------------------------------------------
module u8d_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    input  wire u8d_pkg::cmd_t            cmd,
    output logic                          cmd_pop,
    output logic                          cp_valid,
    output logic [u8d_pkg::CP_W-1:0]      code_point,
    output logic                          last,
    input  wire logic                     cp_stall,
    output u8d_pkg::back_status_t         status
);

    logic [1:0]               br_reg, br_next;
    logic [u8d_pkg::CP_W-1:0] acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic [u8d_pkg::CP_W-1:0] out_cp_reg, out_cp_next;
    logic                     out_last_reg, out_last_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [u8d_pkg::CP_W-1:0] pend_cp_reg, pend_cp_next;

    logic                     out_free;
    logic [u8d_pkg::CP_W-1:0] cont_bits;
    logic [u8d_pkg::CP_W-1:0] acc_or;
    logic                     r0_valid, r0_last, r1_valid;
    logic [u8d_pkg::CP_W-1:0] r0_cp, r1_cp;
    logic [1:0]               br_exec;
    logic [u8d_pkg::CP_W-1:0] acc_exec;

    assign out_free = !out_valid_reg || !cp_stall;
    assign cmd_pop  = cmd_valid && !pend_valid_reg && out_free;

    // Continuation bits placed at the slot of the expected byte
    always_comb
    begin
        unique case (br_reg)
            2'd1:    cont_bits = {15'd0, cmd.value[5:0]};
            2'd2:    cont_bits = {9'd0, cmd.value[5:0], 6'd0};
            2'd3:    cont_bits = {3'd0, cmd.value[5:0], 12'd0};
            default: cont_bits = '0;
        endcase
    end

    assign acc_or = acc_reg | cont_bits;

    // Execute one command against the decode state
    always_comb
    begin
        r0_valid = 1'b0;
        r0_last  = 1'b1;
        r0_cp    = cmd.value;
        r1_valid = 1'b0;
        r1_cp    = cmd.value;
        br_exec  = br_reg;
        acc_exec = acc_reg;
        if (br_reg != 2'd0 && cmd.kind == u8d_pkg::CMD_CONT)
        begin
            br_exec = br_reg - 2'd1;
            if (br_reg == 2'd1)
            begin
                r0_valid = 1'b1;
                r0_cp    = acc_or;
                acc_exec = '0;
            end
            else
            begin
                acc_exec = acc_or;
            end
        end
        else if (br_reg != 2'd0)
        begin
            // cut short: flush partial value, then emit a stand-alone byte or start a new lead
            r0_valid = 1'b1;
            r0_cp    = acc_reg;
            br_exec  = 2'd0;
            acc_exec = '0;
            if (cmd.kind == u8d_pkg::CMD_IMM)
            begin
                r0_last  = 1'b0;
                r1_valid = 1'b1;
            end
            else if (cmd.kind == u8d_pkg::CMD_LEAD)
            begin
                br_exec  = cmd.len;
                acc_exec = cmd.value;
            end
        end
        else
        begin
            case (cmd.kind)
                u8d_pkg::CMD_IMM, u8d_pkg::CMD_CONT:
                begin
                    r0_valid = 1'b1;
                end
                u8d_pkg::CMD_LEAD:
                begin
                    br_exec  = cmd.len;
                    acc_exec = cmd.value;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register and pending slot
    always_comb
    begin
        br_next         = br_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_cp_next     = out_cp_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_cp_next    = pend_cp_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_cp_next     = pend_cp_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (cmd_pop)
        begin
            br_next         = br_exec;
            acc_next        = acc_exec;
            out_valid_next  = r0_valid;
            out_cp_next     = r0_cp;
            out_last_next   = r0_last;
            pend_valid_next = r1_valid;
            pend_cp_next    = r1_cp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg         <= 2'd0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            br_reg         <= br_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cp_reg   <= out_cp_next;
        out_last_reg <= out_last_next;
        pend_cp_reg  <= pend_cp_next;
    end

    assign cp_valid   = out_valid_reg;
    assign code_point = out_cp_reg;
    assign last       = out_last_reg;

    assign status.bytes_remaining = br_reg;
    assign status.accumulator     = acc_reg;
    assign status.pend_valid      = pend_valid_reg;
    assign status.pop             = cmd_pop;

endmodule
`default_nettype wire

// File: rtl/utf8_code_point_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_code_point_decoder - streaming UTF-8 to code point decoder
// Non-validating decoder: one byte word in, zero to two code point words out.
//
// Input channel: byte_valid / byte_stall / byte_in, one byte per word.
// Output channel: cp_valid / cp_stall / code_point / last. last marks the
// final code point caused by one input byte.
// A classifier sorts each accepted byte into a four-word command queue; the
// sequence engine behind it owns the decode state and the output register.
// The byte is registered in the queue when accepted; the engine then takes it
// and shows its first word from the output register. Throughput: one byte per
// cycle while cp_stall is low. A byte that yields two words (a stand-alone
// byte cutting a sequence short) holds the engine while its second word waits
// in the pending slot, a hold the queue absorbs. A zero byte ends a string and
// flushes any partial value. Reset clears the queue, the decode state and the
// output valid. When cp_stall is high the output word holds; the queue keeps
// taking bytes until full, then byte_stall rises.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     byte_valid,
    output logic                          byte_stall,
    input  wire logic [u8d_pkg::BYTE_W-1:0] byte_in,
    output logic                          cp_valid,
    input  wire logic                     cp_stall,
    output logic [u8d_pkg::CP_W-1:0]      code_point,
    output logic                          last
);

    u8d_pkg::cmd_t          front_cmd;
    u8d_pkg::cmd_t          queue_cmd;
    logic                   queue_full;
    logic                   queue_valid;
    logic                   queue_pop;
    u8d_pkg::back_status_t  back_status;

    assign byte_stall = queue_full;

    // Classifier
    u8d_front u_front (
        .byte_in (byte_in),
        .cmd     (front_cmd)
    );

    // Command queue
    u8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_valid),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop_valid (queue_valid),
        .pop_cmd   (queue_cmd),
        .pop       (queue_pop)
    );

    // Sequence engine
    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_valid),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .cp_valid   (cp_valid),
        .code_point (code_point),
        .last       (last),
        .cp_stall   (cp_stall),
        .status     (back_status)
    );

`ifndef SYNTH
    // A pending second word always sits behind a shown first word
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pend_valid |-> cp_valid)
    else $error("pending word without output word");

    // No command is taken while a second word is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pend_valid |-> !back_status.pop)
    else $error("command popped over pending word");

    // Bits below the slot of the next continuation byte are still clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (back_status.bytes_remaining == 2'd1 && back_status.accumulator[5:0] == '0) ||
        (back_status.bytes_remaining == 2'd2 && back_status.accumulator[11:0] == '0) ||
        (back_status.bytes_remaining == 2'd3 && back_status.accumulator[17:0] == '0) ||
        (back_status.bytes_remaining == 2'd0 && back_status.accumulator == '0))
    else $error("accumulator out of step with expected byte count");
`endif

endmodule
`default_nettype wire
